>>> sv/multilevel_feedback_queue_scheduler_macros.svh
// Assertion macros shared by the scheduler modules.
// Needs clk_i and rst_ni in the scope of every module that uses them.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define MLFQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define MLFQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> sv/mlfq_pkg.sv
// Shared types and constants of the feedback-queue scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package mlfq_pkg;

  localparam int unsigned MAX_THREADS = 64;
  localparam int unsigned ID_W        = 6;
  localparam int unsigned ACT_W       = 3;
  localparam int unsigned LVL_W       = 2;
  localparam int unsigned RUN_LVL_W   = 3;
  localparam int unsigned NUM_Q       = 5;
  localparam int unsigned Q_W         = 3;

  localparam logic [Q_W-1:0]   Q_TOP   = 3'd3;
  localparam logic [Q_W-1:0]   Q_BLK   = 3'd4;
  localparam logic [LVL_W-1:0] LVL_TOP = 2'd3;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE = 3'd0,
    ACT_EXPIRE = 3'd1,
    ACT_YIELD  = 3'd2,
    ACT_EXIT   = 3'd3,
    ACT_BLOCK  = 3'd4,
    ACT_WAKE   = 3'd5,
    ACT_BOOST  = 3'd6
  } act_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CREATE,
    OP_RD_CUR,
    OP_REQUEUE,
    OP_PUSH_BLK,
    OP_PICK,
    OP_PICK_LINK,
    OP_WAKE_INIT,
    OP_WAKE_RD,
    OP_WAKE_PUSH,
    OP_MERGE,
    OP_WALK_INIT,
    OP_BOOST_WR,
    OP_BOOST_NX,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e  op;
    logic dec;
  } cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic blk_nonempty;
    logic top_nonempty;
    logic pick_found;
    logic pick_more;
    logic walk_end;
    logic merge_last;
    logic out_busy;
  } sts_t;

endpackage

>>> sv/mlfq_ctrl.sv
// Controller state machine of the feedback-queue scheduler.
// Depends on mlfq_pkg; drives the datapath through mlfq_pkg::cmd_t.
`include "multilevel_feedback_queue_scheduler_macros.svh"

module mlfq_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mlfq_pkg::ACT_W-1:0]     action_i,
  input  mlfq_pkg::sts_t                 sts_i,
  output mlfq_pkg::cmd_t                 cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CREATE,
    S_RD_LVL,
    S_REQUEUE,
    S_BLOCK,
    S_PICK,
    S_PICK_LINK,
    S_WAKE_INIT,
    S_WAKE_RD,
    S_WAKE_PUSH,
    S_MERGE,
    S_BOOST_CHK,
    S_BOOST_WR,
    S_BOOST_NX,
    S_RD_OUT,
    S_FINISH
  } state_e;

  state_e         state_q, state_d;
  logic           in_ready_q;
  mlfq_pkg::act_e act_q;
  logic           accept;

  assign accept     = in_valid_i && in_ready_q;
  assign in_ready_o = in_ready_q;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = mlfq_pkg::OP_NONE;
    cmd_o.dec  = (act_q == mlfq_pkg::ACT_EXPIRE);
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = mlfq_pkg::OP_LOAD;
          case (mlfq_pkg::act_e'(action_i))
            mlfq_pkg::ACT_CREATE: state_d = S_CREATE;
            mlfq_pkg::ACT_EXPIRE, mlfq_pkg::ACT_YIELD: begin
              state_d = sts_i.cur_valid ? S_RD_LVL : S_PICK;
            end
            mlfq_pkg::ACT_EXIT: state_d = S_PICK;
            mlfq_pkg::ACT_BLOCK: begin
              state_d = sts_i.cur_valid ? S_BLOCK : S_PICK;
            end
            mlfq_pkg::ACT_WAKE: begin
              state_d = sts_i.blk_nonempty ? S_WAKE_INIT : S_RD_OUT;
            end
            mlfq_pkg::ACT_BOOST: state_d = S_MERGE;
            default: state_d = S_RD_OUT;
          endcase
        end
      end
      S_CREATE: begin
        cmd_o.op = mlfq_pkg::OP_CREATE;
        state_d  = S_RD_OUT;
      end
      S_RD_LVL: begin
        cmd_o.op = mlfq_pkg::OP_RD_CUR;
        state_d  = S_REQUEUE;
      end
      S_REQUEUE: begin
        cmd_o.op = mlfq_pkg::OP_REQUEUE;
        state_d  = S_PICK;
      end
      S_BLOCK: begin
        cmd_o.op = mlfq_pkg::OP_PUSH_BLK;
        state_d  = S_PICK;
      end
      S_PICK: begin
        cmd_o.op = mlfq_pkg::OP_PICK;
        state_d  = (sts_i.pick_found && sts_i.pick_more) ? S_PICK_LINK : S_RD_OUT;
      end
      S_PICK_LINK: begin
        cmd_o.op = mlfq_pkg::OP_PICK_LINK;
        state_d  = S_RD_OUT;
      end
      S_WAKE_INIT: begin
        cmd_o.op = mlfq_pkg::OP_WAKE_INIT;
        state_d  = S_WAKE_RD;
      end
      S_WAKE_RD: begin
        cmd_o.op = mlfq_pkg::OP_WAKE_RD;
        state_d  = S_WAKE_PUSH;
      end
      S_WAKE_PUSH: begin
        cmd_o.op = mlfq_pkg::OP_WAKE_PUSH;
        state_d  = sts_i.walk_end ? S_RD_OUT : S_WAKE_RD;
      end
      S_MERGE: begin
        cmd_o.op = mlfq_pkg::OP_MERGE;
        state_d  = sts_i.merge_last ? S_BOOST_CHK : S_MERGE;
      end
      S_BOOST_CHK: begin
        if (sts_i.top_nonempty) begin
          cmd_o.op = mlfq_pkg::OP_WALK_INIT;
          state_d  = S_BOOST_WR;
        end else begin
          state_d = S_RD_OUT;
        end
      end
      S_BOOST_WR: begin
        cmd_o.op = mlfq_pkg::OP_BOOST_WR;
        state_d  = sts_i.walk_end ? S_RD_OUT : S_BOOST_NX;
      end
      S_BOOST_NX: begin
        cmd_o.op = mlfq_pkg::OP_BOOST_NX;
        state_d  = S_BOOST_WR;
      end
      S_RD_OUT: begin
        cmd_o.op = mlfq_pkg::OP_RD_CUR;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.op = mlfq_pkg::OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
      act_q      <= mlfq_pkg::ACT_CREATE;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
      if (accept) begin
        act_q <= mlfq_pkg::act_e'(action_i);
      end
    end
  end

  `MLFQ_ASSERT(a_accept_drops_ready, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready stayed high after a word was taken")
  `MLFQ_ASSERT(a_ready_only_idle, in_ready_o |-> (state_q == S_IDLE), "ready high outside the idle state")
  `MLFQ_ASSERT_NEVER(a_finish_when_busy, (cmd_o.op == mlfq_pkg::OP_FINISH) && sts_i.out_busy, "result written over a pending word")

endmodule

>>> sv/mlfq_dp.sv
// Datapath of the feedback-queue scheduler: queue registers, level and link memories.
// Depends on mlfq_pkg; executes mlfq_pkg::cmd_t and reports mlfq_pkg::sts_t.
`include "multilevel_feedback_queue_scheduler_macros.svh"

module mlfq_dp #(
  parameter int unsigned MAX_THREADS_P = mlfq_pkg::MAX_THREADS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mlfq_pkg::ID_W-1:0]         thread_id_i,
  input  mlfq_pkg::cmd_t                    cmd_i,
  output mlfq_pkg::sts_t                    sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              dispatched_o,
  output logic                              run_valid_o,
  output logic [mlfq_pkg::ID_W-1:0]         run_id_o,
  output logic [mlfq_pkg::RUN_LVL_W-1:0]    run_level_o
);

  localparam int unsigned TW        = $clog2(MAX_THREADS_P);
  localparam int unsigned ID_W      = mlfq_pkg::ID_W;
  localparam int unsigned LVL_W     = mlfq_pkg::LVL_W;
  localparam int unsigned RUN_LVL_W = mlfq_pkg::RUN_LVL_W;
  localparam int unsigned NUM_Q     = mlfq_pkg::NUM_Q;
  localparam int unsigned Q_W       = mlfq_pkg::Q_W;
  localparam int unsigned NUM_IDS   = 2 ** ID_W;

  logic [TW-1:0] id_mod [NUM_IDS];

  for (genvar g = 0; g < NUM_IDS; g++) begin : g_id_mod
    localparam int unsigned ModV = g % MAX_THREADS_P;
    assign id_mod[g] = TW'(ModV);
  end

  logic [LVL_W-1:0] lvl_mem  [MAX_THREADS_P];
  logic [TW-1:0]    link_mem [MAX_THREADS_P];

  logic [TW-1:0]    head_q [NUM_Q];
  logic [TW-1:0]    head_d [NUM_Q];
  logic [TW-1:0]    tail_q [NUM_Q];
  logic [TW-1:0]    tail_d [NUM_Q];
  logic [NUM_Q-1:0] ne_q, ne_d;

  logic [TW-1:0]    cur_q, cur_d;
  logic             cur_valid_q, cur_valid_d;
  logic [TW-1:0]    id_q, id_d;
  logic [TW-1:0]    x_q, x_d;
  logic [TW-1:0]    last_q, last_d;
  logic [TW-1:0]    cnt_q, cnt_d;
  logic [1:0]       bq_q, bq_d;
  logic [1:0]       pq_q, pq_d;
  logic             disp_q, disp_d;
  logic [LVL_W-1:0] lvl_rd_q;
  logic [TW-1:0]    link_rd_q;

  logic                 out_valid_q, out_valid_d;
  logic                 dispatched_q, dispatched_d;
  logic                 run_valid_q, run_valid_d;
  logic [ID_W-1:0]      run_id_q, run_id_d;
  logic [RUN_LVL_W-1:0] run_level_q, run_level_d;

  logic             lvl_we, lvl_re, link_we, link_re;
  logic [TW-1:0]    lvl_waddr, lvl_raddr, link_waddr, link_raddr, link_wdata;
  logic [LVL_W-1:0] lvl_wdata;

  logic             push_en;
  logic [Q_W-1:0]   push_q;
  logic [TW-1:0]    push_id;

  logic             pick_found, pick_more;
  logic [1:0]       pick_lvl;
  logic [Q_W-1:0]   pick_qi, bq_qi;
  logic [TW-1:0]    pick_head;
  logic [LVL_W-1:0] req_lvl;

  always_comb begin
    if (ne_q[3]) begin
      pick_lvl = 2'd3;
    end else if (ne_q[2]) begin
      pick_lvl = 2'd2;
    end else if (ne_q[1]) begin
      pick_lvl = 2'd1;
    end else begin
      pick_lvl = 2'd0;
    end
  end

  assign pick_found = |ne_q[3:0];
  assign pick_qi    = {1'b0, pick_lvl};
  assign pick_head  = head_q[pick_qi];
  assign pick_more  = (pick_head != tail_q[pick_qi]);
  assign bq_qi      = {1'b0, bq_q};
  assign req_lvl    = (cmd_i.dec && (lvl_rd_q != '0)) ? lvl_rd_q - 2'd1 : lvl_rd_q;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    ne_d         = ne_q;
    cur_d        = cur_q;
    cur_valid_d  = cur_valid_q;
    id_d         = id_q;
    x_d          = x_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    bq_d         = bq_q;
    pq_d         = pq_q;
    disp_d       = disp_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    dispatched_d = dispatched_q;
    run_valid_d  = run_valid_q;
    run_id_d     = run_id_q;
    run_level_d  = run_level_q;
    lvl_we       = 1'b0;
    lvl_re       = 1'b0;
    link_we      = 1'b0;
    link_re      = 1'b0;
    lvl_waddr    = cur_q;
    lvl_raddr    = cur_q;
    lvl_wdata    = mlfq_pkg::LVL_TOP;
    link_waddr   = tail_q[mlfq_pkg::Q_TOP];
    link_raddr   = x_q;
    link_wdata   = '0;
    push_en      = 1'b0;
    push_q       = mlfq_pkg::Q_TOP;
    push_id      = cur_q;

    case (cmd_i.op)
      mlfq_pkg::OP_LOAD: begin
        id_d   = id_mod[thread_id_i];
        disp_d = 1'b0;
        bq_d   = 2'd2;
      end
      mlfq_pkg::OP_CREATE: begin
        lvl_we    = 1'b1;
        lvl_waddr = id_q;
        lvl_wdata = mlfq_pkg::LVL_TOP;
        push_en   = 1'b1;
        push_q    = mlfq_pkg::Q_TOP;
        push_id   = id_q;
      end
      mlfq_pkg::OP_RD_CUR: begin
        lvl_re    = 1'b1;
        lvl_raddr = cur_q;
      end
      mlfq_pkg::OP_REQUEUE: begin
        lvl_we    = 1'b1;
        lvl_waddr = cur_q;
        lvl_wdata = req_lvl;
        push_en   = 1'b1;
        push_q    = {1'b0, req_lvl};
        push_id   = cur_q;
      end
      mlfq_pkg::OP_PUSH_BLK: begin
        push_en = 1'b1;
        push_q  = mlfq_pkg::Q_BLK;
        push_id = cur_q;
      end
      mlfq_pkg::OP_PICK: begin
        if (pick_found) begin
          cur_d       = pick_head;
          cur_valid_d = 1'b1;
          disp_d      = 1'b1;
          pq_d        = pick_lvl;
          if (pick_more) begin
            link_re    = 1'b1;
            link_raddr = pick_head;
          end else begin
            ne_d[pick_qi] = 1'b0;
          end
        end else begin
          cur_valid_d = 1'b0;
        end
      end
      mlfq_pkg::OP_PICK_LINK: begin
        head_d[{1'b0, pq_q}] = link_rd_q;
      end
      mlfq_pkg::OP_WAKE_INIT: begin
        x_d                   = head_q[mlfq_pkg::Q_BLK];
        last_d                = tail_q[mlfq_pkg::Q_BLK];
        ne_d[mlfq_pkg::Q_BLK] = 1'b0;
        cnt_d                 = '0;
      end
      mlfq_pkg::OP_WAKE_RD: begin
        lvl_re     = 1'b1;
        lvl_raddr  = x_q;
        link_re    = 1'b1;
        link_raddr = x_q;
      end
      mlfq_pkg::OP_WAKE_PUSH: begin
        push_en = 1'b1;
        push_q  = {1'b0, lvl_rd_q};
        push_id = x_q;
        x_d     = link_rd_q;
        cnt_d   = cnt_q + TW'(1);
      end
      mlfq_pkg::OP_MERGE: begin
        if (ne_q[bq_qi]) begin
          if (ne_q[mlfq_pkg::Q_TOP]) begin
            link_we    = 1'b1;
            link_waddr = tail_q[mlfq_pkg::Q_TOP];
            link_wdata = head_q[bq_qi];
          end else begin
            head_d[mlfq_pkg::Q_TOP] = head_q[bq_qi];
            ne_d[mlfq_pkg::Q_TOP]   = 1'b1;
          end
          tail_d[mlfq_pkg::Q_TOP] = tail_q[bq_qi];
          ne_d[bq_qi]             = 1'b0;
        end
        bq_d = bq_q - 2'd1;
      end
      mlfq_pkg::OP_WALK_INIT: begin
        x_d    = head_q[mlfq_pkg::Q_TOP];
        last_d = tail_q[mlfq_pkg::Q_TOP];
        cnt_d  = '0;
      end
      mlfq_pkg::OP_BOOST_WR: begin
        lvl_we     = 1'b1;
        lvl_waddr  = x_q;
        lvl_wdata  = mlfq_pkg::LVL_TOP;
        link_re    = 1'b1;
        link_raddr = x_q;
      end
      mlfq_pkg::OP_BOOST_NX: begin
        x_d   = link_rd_q;
        cnt_d = cnt_q + TW'(1);
      end
      mlfq_pkg::OP_FINISH: begin
        out_valid_d  = 1'b1;
        dispatched_d = disp_q;
        run_valid_d  = cur_valid_q;
        run_id_d     = cur_valid_q ? ID_W'(cur_q) : '0;
        run_level_d  = cur_valid_q ? ({1'b0, lvl_rd_q} + RUN_LVL_W'(1)) : '0;
      end
      default: begin
      end
    endcase

    if (push_en) begin
      if (ne_q[push_q]) begin
        link_we    = 1'b1;
        link_waddr = tail_q[push_q];
        link_wdata = push_id;
      end else begin
        head_d[push_q] = push_id;
        ne_d[push_q]   = 1'b1;
      end
      tail_d[push_q] = push_id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
    if (lvl_re) begin
      lvl_rd_q <= lvl_mem[lvl_raddr];
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_Q; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      ne_q        <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      ne_q        <= ne_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    x_q          <= x_d;
    last_q       <= last_d;
    cnt_q        <= cnt_d;
    bq_q         <= bq_d;
    pq_q         <= pq_d;
    disp_q       <= disp_d;
    dispatched_q <= dispatched_d;
    run_valid_q  <= run_valid_d;
    run_id_q     <= run_id_d;
    run_level_q  <= run_level_d;
  end

  assign sts_o.cur_valid    = cur_valid_q;
  assign sts_o.blk_nonempty = ne_q[mlfq_pkg::Q_BLK];
  assign sts_o.top_nonempty = ne_q[mlfq_pkg::Q_TOP];
  assign sts_o.pick_found   = pick_found;
  assign sts_o.pick_more    = pick_more;
  assign sts_o.walk_end     = (x_q == last_q) || (cnt_q == TW'(MAX_THREADS_P - 1));
  assign sts_o.merge_last   = (bq_q == 2'd0);
  assign sts_o.out_busy     = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign dispatched_o = dispatched_q;
  assign run_valid_o  = run_valid_q;
  assign run_id_o     = run_id_q;
  assign run_level_o  = run_level_q;

  `MLFQ_ASSERT(a_pick_runs, ((cmd_i.op == mlfq_pkg::OP_PICK) && pick_found) |=> cur_valid_q, "dispatch left nothing running")
  `MLFQ_ASSERT(a_idle_word_zero, (out_valid_q && !run_valid_q) |-> ((run_id_q == '0) && (run_level_q == '0)), "idle result carries a thread")
  `MLFQ_ASSERT_NEVER(a_blk_push_src, push_en && (push_q == mlfq_pkg::Q_BLK) && (cmd_i.op != mlfq_pkg::OP_PUSH_BLK), "thread pushed to the blocked list by a wrong operation")

endmodule

>>> sv/multilevel_feedback_queue_scheduler.sv
// Four-level feedback-queue thread scheduler, top level.
// Depends on mlfq_pkg, mlfq_ctrl and mlfq_dp.
//
// Each accepted word (action, thread id) yields exactly one result word
// (dispatched, run valid, run id, run level). Items are handled one at a time.
// Wake-all walks the blocked list, and boost walks the top-level list after
// merging the lower levels into it. Every list walk goes through the level and
// link memories one entry per step, since each has a single read port.
// A finished result is held in an output register, so a stalled consumer only
// delays the next result, not the next accept.
module multilevel_feedback_queue_scheduler #(
  parameter int unsigned MAX_THREADS_P = mlfq_pkg::MAX_THREADS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mlfq_pkg::ACT_W-1:0]        action_i,
  input  logic [mlfq_pkg::ID_W-1:0]         thread_id_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              dispatched_o,
  output logic                              run_valid_o,
  output logic [mlfq_pkg::ID_W-1:0]         run_id_o,
  output logic [mlfq_pkg::RUN_LVL_W-1:0]    run_level_o
);

  mlfq_pkg::cmd_t cmd;
  mlfq_pkg::sts_t sts;

  mlfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mlfq_dp #(
    .MAX_THREADS_P (MAX_THREADS_P)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .thread_id_i  (thread_id_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .dispatched_o (dispatched_o),
    .run_valid_o  (run_valid_o),
    .run_id_o     (run_id_o),
    .run_level_o  (run_level_o)
  );

endmodule
